>>> hw/rtl/smf_pkg.sv
package smf_pkg;

  typedef enum logic [1:0] {
    FR_LINE     = 2'd0,
    FR_AFTER_LF = 2'd1,
    FR_BODY     = 2'd2
  } frame_phase_e;

  typedef enum logic [2:0] {
    VP_NAME       = 3'd0,
    VP_PRE_COLON  = 3'd1,
    VP_POST_COLON = 3'd2,
    VP_DIGITS     = 3'd3,
    VP_SKIP       = 3'd4
  } value_phase_e;

  // Candidate bits: bit 0 is the long form, bit 1 the short form.
  localparam logic [1:0] CAND_NONE  = 2'b00;
  localparam logic [1:0] CAND_LONG  = 2'b01;
  localparam logic [1:0] CAND_SHORT = 2'b10;
  localparam logic [1:0] CAND_BOTH  = 2'b11;

  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_VT    = 8'h0B;
  localparam logic [7:0] CHR_FF    = 8'h0C;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_UP_A  = 8'h41;
  localparam logic [7:0] CHR_UP_Z  = 8'h5A;
  localparam logic [7:0] CHR_SHORT = 8'h6C;

  localparam logic [3:0] LONG_NAME_LEN = 4'd14;

  // Lower-case spelling of the long header name, one character per position.
  function automatic logic [7:0] long_name_char(input logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = 8'h63; // c
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2D; // -
      4'd8:    ch = 8'h6C; // l
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6E; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] ch);
    logic [7:0] res;
    if (ch >= CHR_UP_A && ch <= CHR_UP_Z) begin
      res = ch + 8'd32;
    end else begin
      res = ch;
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/smf_stream_if.sv
interface smf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface smf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        in_body;
  logic        message_end;
  logic [15:0] body_length;

  modport source (output valid, output out_byte, output in_body, output message_end,
                  output body_length, input ready);
  modport sink (input valid, input out_byte, input in_body, input message_end,
                input body_length, output ready);
endinterface

>>> hw/rtl/sip_stream_message_framer_top.sv
// Byte stream framer for SIP-style messages. Every accepted byte comes out once, registered,
// tagged as header or body; the header ends at a second line feed (carriage returns
// may sit between the two), and the body length comes from the first Content-Length value,
// else the first short-form "l" value, else zero, saturating at 2^LENGTH_WIDTH - 1.
// message_end marks the final byte of each message, after which the framer starts over.
// The block takes one byte per clock cycle while the output is read: the name matcher, the
// digit accumulator and the body counter are combinational ahead of the result register, and a new
// byte is accepted whenever the result register is empty or is being read in that cycle.
module sip_stream_message_framer_top
  import smf_pkg::*;
#(
  parameter int LENGTH_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  smf_in_if.sink    in_i,
  smf_out_if.source out_o
);

  localparam int LW = LENGTH_WIDTH;

  frame_phase_e      frame_q, frame_d;
  logic [3:0]        pos_q, pos_d;
  logic [1:0]        cand_q, cand_d;
  value_phase_e      vp_q, vp_d;
  logic              neg_q, neg_d;
  logic [LW-1:0]     lval_q, lval_d;
  logic              lfound_q, lfound_d;
  logic              lneg_q, lneg_d;
  logic [LW-1:0]     sval_q, sval_d;
  logic              sfound_q, sfound_d;
  logic              sneg_q, sneg_d;
  logic [LW-1:0]     cnt_q, cnt_d;
  logic [LW-1:0]     msglen_q, msglen_d;

  // Next values produced by the header matcher.
  logic [3:0]        m_pos;
  logic [1:0]        m_cand;
  value_phase_e      m_vp;
  logic              m_neg;
  logic [LW-1:0]     m_lval, m_sval;
  logic              m_lfound, m_lneg, m_sfound, m_sneg;

  logic [7:0]        b;
  logic [7:0]        lc;
  logic              is_digit;
  logic              long_sel;
  logic [LW-1:0]     acc_in;
  logic [LW+3:0]     acc_sum;
  logic [LW-1:0]     acc_sat;

  logic              accept;
  logic              hdr_end;
  logic [LW-1:0]     len;
  logic [LW-1:0]     cnt_dec;
  logic              body_end;

  logic              res_body, res_end;
  logic [LW-1:0]     res_len;
  logic [LW+15:0]    res_len_ext;

  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  logic              out_body_q;
  logic              out_end_q;
  logic [15:0]       out_len_q;

  assign b        = in_i.stream_byte;
  assign lc       = to_lower(b);
  assign is_digit = (b >= CHR_ZERO) && (b <= CHR_NINE);
  assign long_sel = (cand_q == CAND_LONG);

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // Decimal accumulator: value * 10 + digit, clamped to the all-ones length.
  assign acc_in  = long_sel ? lval_q : sval_q;
  assign acc_sum = {1'b0, acc_in, 3'b000} + {3'b000, acc_in, 1'b0}
                 + {{LW{1'b0}}, b[3:0]};
  assign acc_sat = (acc_sum[LW+3:LW] != 4'd0) ? {LW{1'b1}} : acc_sum[LW-1:0];

  always_comb begin
    m_pos    = pos_q;
    m_cand   = cand_q;
    m_vp     = vp_q;
    m_neg    = neg_q;
    m_lval   = lval_q;
    m_lfound = lfound_q;
    m_lneg   = lneg_q;
    m_sval   = sval_q;
    m_sfound = sfound_q;
    m_sneg   = sneg_q;
    if (b == CHR_LF) begin
      // A line feed closes any value in progress and arms matching for the next line.
      if (vp_q == VP_DIGITS && neg_q) begin
        if (cand_q == CAND_LONG && lval_q != '0) m_lneg = 1'b1;
        if (cand_q == CAND_SHORT && sval_q != '0) m_sneg = 1'b1;
      end
      m_pos  = 4'd0;
      m_cand = CAND_BOTH;
      m_vp   = VP_NAME;
      m_neg  = 1'b0;
    end else begin
      unique case (vp_q)
        VP_NAME: begin
          if (cand_q != CAND_NONE) begin
            if (pos_q == 4'd0) begin
              if (lc == CHR_SHORT && cand_q[1]) begin
                m_cand = CAND_SHORT;
                m_vp   = VP_PRE_COLON;
              end else if (lc == long_name_char(4'd0) && cand_q[0]) begin
                m_cand = CAND_LONG;
                m_pos  = 4'd1;
              end else begin
                m_cand = CAND_NONE;
              end
            end else if (pos_q < LONG_NAME_LEN && lc == long_name_char(pos_q)) begin
              m_pos = pos_q + 4'd1;
              if (pos_q + 4'd1 == LONG_NAME_LEN) m_vp = VP_PRE_COLON;
            end else begin
              m_cand = CAND_NONE;
            end
          end
        end
        VP_PRE_COLON: begin
          if (b == CHR_SPACE || b == CHR_TAB) begin
            m_vp = VP_PRE_COLON;
          end else if (b == CHR_COLON) begin
            // Only the first occurrence of each form is taken.
            if (long_sel ? lfound_q : sfound_q) begin
              m_vp = VP_SKIP;
            end else begin
              if (long_sel) begin
                m_lfound = 1'b1;
                m_lval   = '0;
              end else begin
                m_sfound = 1'b1;
                m_sval   = '0;
              end
              m_neg = 1'b0;
              m_vp  = VP_POST_COLON;
            end
          end else begin
            m_cand = CAND_NONE;
            m_vp   = VP_NAME;
          end
        end
        VP_POST_COLON: begin
          if (b == CHR_SPACE || b == CHR_TAB || b == CHR_CR || b == CHR_VT
              || b == CHR_FF) begin
            m_vp = VP_POST_COLON;
          end else if (b == CHR_PLUS) begin
            m_vp = VP_DIGITS;
          end else if (b == CHR_MINUS) begin
            m_neg = 1'b1;
            m_vp  = VP_DIGITS;
          end else if (is_digit) begin
            if (long_sel) m_lval = acc_sat;
            else m_sval = acc_sat;
            m_vp = VP_DIGITS;
          end else begin
            m_vp = VP_SKIP;
          end
        end
        VP_DIGITS: begin
          if (is_digit) begin
            if (long_sel) m_lval = acc_sat;
            else m_sval = acc_sat;
          end else begin
            if (neg_q) begin
              if (cand_q == CAND_LONG && lval_q != '0) m_lneg = 1'b1;
              if (cand_q == CAND_SHORT && sval_q != '0) m_sneg = 1'b1;
            end
            m_vp = VP_SKIP;
          end
        end
        default: begin
          m_vp = vp_q;
        end
      endcase
    end
  end

  assign hdr_end = (frame_q == FR_AFTER_LF) && (b == CHR_LF);
  assign len     = (m_lfound && !m_lneg) ? m_lval
                 : (m_sfound && !m_sneg) ? m_sval : '0;
  assign cnt_dec  = cnt_q - {{(LW-1){1'b0}}, (cnt_q != '0)};
  assign body_end = (cnt_dec == '0);

  // Next-state logic of the frame sequencer.
  always_comb begin
    frame_d  = frame_q;
    pos_d    = pos_q;
    cand_d   = cand_q;
    vp_d     = vp_q;
    neg_d    = neg_q;
    lval_d   = lval_q;
    lfound_d = lfound_q;
    lneg_d   = lneg_q;
    sval_d   = sval_q;
    sfound_d = sfound_q;
    sneg_d   = sneg_q;
    cnt_d    = cnt_q;
    msglen_d = msglen_q;
    if (frame_q == FR_BODY) begin
      cnt_d = cnt_dec;
    end else begin
      pos_d    = m_pos;
      cand_d   = m_cand;
      vp_d     = m_vp;
      neg_d    = m_neg;
      lval_d   = m_lval;
      lfound_d = m_lfound;
      lneg_d   = m_lneg;
      sval_d   = m_sval;
      sfound_d = m_sfound;
      sneg_d   = m_sneg;
      if (hdr_end) begin
        frame_d  = FR_BODY;
        msglen_d = len;
        cnt_d    = len;
      end else if (b == CHR_LF) begin
        frame_d = FR_AFTER_LF;
      end else if (b != CHR_CR) begin
        frame_d = FR_LINE;
      end
    end
    // The last byte of a message returns the whole framer to its reset state.
    if (res_end) begin
      frame_d  = FR_LINE;
      pos_d    = 4'd0;
      cand_d   = CAND_NONE;
      vp_d     = VP_NAME;
      neg_d    = 1'b0;
      lval_d   = '0;
      lfound_d = 1'b0;
      lneg_d   = 1'b0;
      sval_d   = '0;
      sfound_d = 1'b0;
      sneg_d   = 1'b0;
      cnt_d    = '0;
      msglen_d = '0;
    end
  end

  // Result of the current byte.
  always_comb begin
    unique case (frame_q)
      FR_BODY: begin
        res_body = 1'b1;
        res_end  = body_end;
        res_len  = msglen_q;
      end
      FR_LINE, FR_AFTER_LF: begin
        res_body = 1'b0;
        res_end  = hdr_end && (len == '0);
        res_len  = hdr_end ? len : '0;
      end
      default: begin
        res_body = 1'b0;
        res_end  = 1'b0;
        res_len  = '0;
      end
    endcase
  end

  assign res_len_ext = {16'd0, res_len};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q  <= FR_LINE;
      pos_q    <= 4'd0;
      cand_q   <= CAND_NONE;
      vp_q     <= VP_NAME;
      neg_q    <= 1'b0;
      lval_q   <= '0;
      lfound_q <= 1'b0;
      lneg_q   <= 1'b0;
      sval_q   <= '0;
      sfound_q <= 1'b0;
      sneg_q   <= 1'b0;
      cnt_q    <= '0;
      msglen_q <= '0;
    end else if (accept) begin
      frame_q  <= frame_d;
      pos_q    <= pos_d;
      cand_q   <= cand_d;
      vp_q     <= vp_d;
      neg_q    <= neg_d;
      lval_q   <= lval_d;
      lfound_q <= lfound_d;
      lneg_q   <= lneg_d;
      sval_q   <= sval_d;
      sfound_q <= sfound_d;
      sneg_q   <= sneg_d;
      cnt_q    <= cnt_d;
      msglen_q <= msglen_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_byte_q <= b;
      out_body_q <= res_body;
      out_end_q  <= res_end;
      out_len_q  <= res_len_ext[15:0];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.in_body     = out_body_q;
  assign out_o.message_end = out_end_q;
  assign out_o.body_length = out_len_q;

endmodule
